// ----- src/lsrd_pkg.sv -----
// Shared types and constants for the laser scan reply distance decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package lsrd_pkg;

  localparam int BYTE_W  = 8;
  localparam int RANGE_W = 14;
  localparam int STEP_W  = 10;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 2);

  localparam logic [BYTE_W-1:0] CHAR_M    = 8'h4D;
  localparam logic [BYTE_W-1:0] CHAR_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_B    = 8'h62;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [31:0]       CHAR_BASE = 32'h30;

  localparam logic [2:0]        SKIP_LAST = 3'd6;
  localparam logic [STEP_W-1:0] STEP_MAX  = 10'd1023;

  localparam logic [STEP_W-1:0]  FIRST_STEP_RESET   = 10'd44;
  localparam logic [RANGE_W-1:0] MAX_DISTANCE_RESET = 14'd4000;

  localparam logic REG_FIRST_STEP   = 1'b0;
  localparam logic REG_MAX_DISTANCE = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0]  first_step;
    logic [RANGE_W-1:0] max_distance;
  } lsrd_cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_value;
    logic [STEP_W-1:0]  step_index;
    logic               scan_end;
  } lsrd_result_t;

endpackage

`default_nettype wire

// ----- src/lsrd_regs.sv -----
// APB-style configuration registers: first_step and max_distance.
// Depends on lsrd_pkg.
`default_nettype none

module lsrd_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [lsrd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lsrd_pkg::DATA_W-1:0] pwdata,
  output logic      [lsrd_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output lsrd_pkg::lsrd_cfg_t            cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_step   <= lsrd_pkg::FIRST_STEP_RESET;
      cfg.max_distance <= lsrd_pkg::MAX_DISTANCE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == lsrd_pkg::REG_FIRST_STEP) begin
        cfg.first_step <= pwdata[lsrd_pkg::STEP_W-1:0];
      end else begin
        cfg.max_distance <= pwdata[lsrd_pkg::RANGE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lsrd_pkg::REG_FIRST_STEP) begin
      prdata = {{(lsrd_pkg::DATA_W-lsrd_pkg::STEP_W){1'b0}}, cfg.first_step};
    end else begin
      prdata = {{(lsrd_pkg::DATA_W-lsrd_pkg::RANGE_W){1'b0}}, cfg.max_distance};
    end
  end

endmodule

`default_nettype wire

// ----- src/lsrd_parse.sv -----
// Input byte register and reply parser: header hunt, skip, pair decode.
// Depends on lsrd_pkg.
`default_nettype none

module lsrd_parse (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_fire,
  input  wire logic [lsrd_pkg::BYTE_W-1:0]   rx_byte,
  input  wire lsrd_pkg::lsrd_cfg_t           cfg,
  output logic                               stage_v,
  output logic                               push,
  output lsrd_pkg::lsrd_result_t             res
);

  typedef enum logic [1:0] {HUNT_MS, HUNT_99B, SKIP, DATA} phase_t;

  logic [lsrd_pkg::BYTE_W-1:0] byte_q;
  phase_t                      phase, phase_next;
  logic [1:0]                  match_progress, match_progress_next;
  logic [2:0]                  skip_count, skip_count_next;
  logic [lsrd_pkg::BYTE_W-1:0] held_char, held_char_next;
  logic                        pair_position, pair_position_next;
  logic                        last_lf, last_lf_next;
  logic [lsrd_pkg::STEP_W-1:0] pair_counter, pair_counter_next;

  logic [31:0]                 dist_wide;
  logic [lsrd_pkg::STEP_W:0]   idx_sum;
  logic                        is_lf;

  assign is_lf   = (byte_q == lsrd_pkg::CHAR_LF);
  assign idx_sum = {1'b0, cfg.first_step} + {1'b0, pair_counter};
  assign dist_wide = (({24'b0, held_char} - lsrd_pkg::CHAR_BASE) << 6)
                   | ({24'b0, byte_q} - lsrd_pkg::CHAR_BASE);

  always_comb begin
    phase_next          = phase;
    match_progress_next = match_progress;
    skip_count_next     = skip_count;
    held_char_next      = held_char;
    pair_position_next  = pair_position;
    last_lf_next        = last_lf;
    pair_counter_next   = pair_counter;
    push                = 1'b0;
    res                 = '0;
    if (stage_v) begin
      case (phase)
        HUNT_99B: begin
          if (is_lf && last_lf) begin
            phase_next          = HUNT_MS;
            match_progress_next = 2'd0;
            last_lf_next        = 1'b0;
          end else begin
            last_lf_next = is_lf;
            if (match_progress == 2'd2 && byte_q == lsrd_pkg::CHAR_B) begin
              phase_next          = SKIP;
              match_progress_next = 2'd0;
              skip_count_next     = 3'd0;
            end else if (byte_q == lsrd_pkg::CHAR_NINE) begin
              match_progress_next = (match_progress != 2'd0) ? 2'd2 : 2'd1;
            end else begin
              match_progress_next = 2'd0;
            end
          end
        end
        SKIP: begin
          if (skip_count == lsrd_pkg::SKIP_LAST) begin
            phase_next         = DATA;
            skip_count_next    = 3'd0;
            pair_position_next = 1'b0;
            held_char_next     = '0;
            last_lf_next       = 1'b0;
            pair_counter_next  = '0;
          end else begin
            skip_count_next = skip_count + 3'd1;
          end
        end
        DATA: begin
          if (is_lf) begin
            if (last_lf) begin
              push                = 1'b1;
              res.scan_end        = 1'b1;
              phase_next          = HUNT_MS;
              match_progress_next = 2'd0;
              skip_count_next     = 3'd0;
              held_char_next      = '0;
              pair_position_next  = 1'b0;
              last_lf_next        = 1'b0;
              pair_counter_next   = '0;
            end else begin
              last_lf_next       = 1'b1;
              pair_position_next = 1'b0;
              held_char_next     = '0;
            end
          end else begin
            last_lf_next = 1'b0;
            if (!pair_position) begin
              held_char_next     = byte_q;
              pair_position_next = 1'b1;
            end else begin
              push = 1'b1;
              if (dist_wide > {{(32-lsrd_pkg::RANGE_W){1'b0}}, cfg.max_distance}) begin
                res.range_value = cfg.max_distance;
              end else begin
                res.range_value = dist_wide[lsrd_pkg::RANGE_W-1:0];
              end
              res.step_index = idx_sum[lsrd_pkg::STEP_W] ? lsrd_pkg::STEP_MAX
                                                         : idx_sum[lsrd_pkg::STEP_W-1:0];
              pair_position_next = 1'b0;
              held_char_next     = '0;
              if (pair_counter != lsrd_pkg::STEP_MAX) begin
                pair_counter_next = pair_counter + 10'd1;
              end
            end
          end
        end
        default: begin
          phase_next = HUNT_MS;
          if (match_progress == 2'd1 && byte_q == lsrd_pkg::CHAR_S) begin
            phase_next          = HUNT_99B;
            match_progress_next = 2'd0;
            last_lf_next        = 1'b0;
          end else begin
            match_progress_next = (byte_q == lsrd_pkg::CHAR_M) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v        <= 1'b0;
      phase          <= HUNT_MS;
      match_progress <= 2'd0;
      skip_count     <= 3'd0;
      held_char      <= '0;
      pair_position  <= 1'b0;
      last_lf        <= 1'b0;
      pair_counter   <= '0;
    end else begin
      stage_v        <= in_fire;
      phase          <= phase_next;
      match_progress <= match_progress_next;
      skip_count     <= skip_count_next;
      held_char      <= held_char_next;
      pair_position  <= pair_position_next;
      last_lf        <= last_lf_next;
      pair_counter   <= pair_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_q <= rx_byte;
    end
  end

`ifndef SYNTH
  a_push_needs_byte: assert property (@(posedge clk) disable iff (rst)
    push |-> stage_v) else $error("result without a staged byte");
  a_fire_stages: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> stage_v) else $error("accepted item not staged");
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    push && res.scan_end |-> res.range_value == '0 && res.step_index == '0)
    else $error("scan end marker carries data");
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    push && !res.scan_end |-> res.range_value <= cfg.max_distance)
    else $error("distance above clamp");
`endif

endmodule

`default_nettype wire

// ----- src/lsrd_outq.sv -----
// Small result queue between the parser and the output channel.
// Depends on lsrd_pkg.
`default_nettype none

module lsrd_outq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire lsrd_pkg::lsrd_result_t        push_data,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output lsrd_pkg::lsrd_result_t             head,
  output logic [lsrd_pkg::QCNT_W-1:0]        count
);

  lsrd_pkg::lsrd_result_t           mem [lsrd_pkg::QUEUE_DEPTH];
  logic [lsrd_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic                             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{(lsrd_pkg::QCNT_W-1){1'b0}}, push}
                     - {{(lsrd_pkg::QCNT_W-1){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/laser_scan_reply_distance_decoder_top.sv -----
// Top level of the laser scan reply distance decoder.
// Depends on lsrd_pkg, lsrd_regs, lsrd_parse, lsrd_outq.
//
// Takes one reply byte per cycle when in_ready is high. An accepted byte is
// registered, then parsed in the next cycle (header hunt for "MS" and "99b",
// seven skipped bytes, two-character distance pairs, LF LF end marker); a
// result is then queued and offered at out_valid. Sustained rate is one item
// per cycle absent stalls, set by the single parse stage; a four-entry
// result queue buffers waiting results, and in_ready drops when queued
// results and the staged byte reach four. The user must write configuration
// through the APB port while the block is idle; nothing enforces this.
`default_nettype none

module laser_scan_reply_distance_decoder_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lsrd_pkg::BYTE_W-1:0]     rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [lsrd_pkg::RANGE_W-1:0]    range_value,
  output logic      [lsrd_pkg::STEP_W-1:0]     step_index,
  output logic                                 scan_end,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lsrd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [lsrd_pkg::DATA_W-1:0]     pwdata,
  output logic      [lsrd_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready
);

  lsrd_pkg::lsrd_cfg_t             cfg;
  lsrd_pkg::lsrd_result_t          res;
  lsrd_pkg::lsrd_result_t          head;
  logic                            stage_v;
  logic                            push;
  logic                            in_fire;
  logic [lsrd_pkg::QCNT_W-1:0]     count;
  logic [lsrd_pkg::QCNT_W-1:0]     occupied;

  assign occupied = count + {{(lsrd_pkg::QCNT_W-1){1'b0}}, stage_v};
  assign in_ready = (occupied < lsrd_pkg::QCNT_W'(lsrd_pkg::QUEUE_DEPTH));
  assign in_fire  = in_valid && in_ready;

  assign range_value = head.range_value;
  assign step_index  = head.step_index;
  assign scan_end    = head.scan_end;

  lsrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsrd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .stage_v (stage_v),
    .push    (push),
    .res     (res)
  );

  lsrd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (count)
  );

endmodule

`default_nettype wire

// ----- tb/laser_scan_reply_distance_decoder_top_tb.sv -----
// Testbench for laser_scan_reply_distance_decoder_top: reply byte streams in,
// range items checked against an in-bench decoder model.
// Depends on lsrd_pkg and the decoder RTL only.
module laser_scan_reply_distance_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STAMP_BYTES = 7;
  localparam int DRAIN_SLACK = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 40;
  localparam logic [lsrd_pkg::BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [lsrd_pkg::BYTE_W-1:0] CHAR_TOP  = 8'h6F;

  typedef enum logic [1:0] {HUNT_HEADER, HUNT_STATUS, SKIP_STAMP, DECODE_DATA} parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [lsrd_pkg::BYTE_W-1:0] rx_byte = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lsrd_pkg::ADDR_W-1:0] paddr = '0;
  logic [lsrd_pkg::DATA_W-1:0] pwdata = '0;
  logic in_ready;
  logic out_valid;
  logic [lsrd_pkg::RANGE_W-1:0] range_value;
  logic [lsrd_pkg::STEP_W-1:0] step_index;
  logic scan_end;
  logic [lsrd_pkg::DATA_W-1:0] prdata;
  logic pready;

  laser_scan_reply_distance_decoder_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .range_value(range_value), .step_index(step_index), .scan_end(scan_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // decoder model state
  parse_phase_t parse_phase = HUNT_HEADER;
  logic [1:0] match_cnt = '0;
  logic [2:0] stamp_cnt = '0;
  logic [lsrd_pkg::BYTE_W-1:0] held_char = '0;
  logic pair_half = 1'b0;
  logic lf_seen = 1'b0;
  logic [lsrd_pkg::STEP_W-1:0] pair_count = '0;
  logic [lsrd_pkg::STEP_W-1:0] cfg_first_step = lsrd_pkg::FIRST_STEP_RESET;
  logic [lsrd_pkg::RANGE_W-1:0] cfg_max_distance = lsrd_pkg::MAX_DISTANCE_RESET;

  lsrd_pkg::lsrd_result_t expected_results[$];
  int error_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void restart_hunt();
    parse_phase = HUNT_HEADER;
    match_cnt = '0;
    stamp_cnt = '0;
    held_char = '0;
    pair_half = 1'b0;
    lf_seen = 1'b0;
    pair_count = '0;
  endfunction

  function automatic bit decode_byte(input logic [lsrd_pkg::BYTE_W-1:0] b,
                                     output lsrd_pkg::lsrd_result_t res);
    logic [31:0] range_calc;
    logic [31:0] idx;
    res = '0;
    case (parse_phase)
      HUNT_STATUS: begin
        if (b == lsrd_pkg::CHAR_LF && lf_seen) begin
          restart_hunt();
          return 1'b0;
        end
        lf_seen = (b == lsrd_pkg::CHAR_LF);
        if (match_cnt == 2'd2 && b == lsrd_pkg::CHAR_B) begin
          parse_phase = SKIP_STAMP;
          match_cnt = '0;
          stamp_cnt = '0;
        end else if (b == lsrd_pkg::CHAR_NINE) begin
          match_cnt = (match_cnt >= 2'd1) ? 2'd2 : 2'd1;
        end else begin
          match_cnt = '0;
        end
        return 1'b0;
      end
      SKIP_STAMP: begin
        stamp_cnt = stamp_cnt + 3'd1;
        if (stamp_cnt >= STAMP_BYTES) begin
          parse_phase = DECODE_DATA;
          stamp_cnt = '0;
          pair_half = 1'b0;
          held_char = '0;
          lf_seen = 1'b0;
          pair_count = '0;
        end
        return 1'b0;
      end
      DECODE_DATA: begin
        if (b == lsrd_pkg::CHAR_LF) begin
          if (lf_seen) begin
            res.scan_end = 1'b1;
            restart_hunt();
            return 1'b1;
          end
          lf_seen = 1'b1;
          pair_half = 1'b0;
          held_char = '0;
          return 1'b0;
        end
        lf_seen = 1'b0;
        if (!pair_half) begin
          held_char = b;
          pair_half = 1'b1;
          return 1'b0;
        end
        range_calc = ((32'(held_char) - lsrd_pkg::CHAR_BASE) << 6)
                   | (32'(b) - lsrd_pkg::CHAR_BASE);
        idx = 32'(cfg_first_step) + 32'(pair_count);
        if (range_calc > 32'(cfg_max_distance)) range_calc = 32'(cfg_max_distance);
        if (idx > 32'(lsrd_pkg::STEP_MAX)) idx = 32'(lsrd_pkg::STEP_MAX);
        res.range_value = range_calc[lsrd_pkg::RANGE_W-1:0];
        res.step_index = idx[lsrd_pkg::STEP_W-1:0];
        pair_half = 1'b0;
        held_char = '0;
        if (pair_count < lsrd_pkg::STEP_MAX) pair_count = pair_count + 1'b1;
        return 1'b1;
      end
      default: begin
        parse_phase = HUNT_HEADER;
        if (match_cnt == 2'd1 && b == lsrd_pkg::CHAR_S) begin
          parse_phase = HUNT_STATUS;
          match_cnt = '0;
          lf_seen = 1'b0;
        end else begin
          match_cnt = (b == lsrd_pkg::CHAR_M) ? 2'd1 : 2'd0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("laser_scan_reply_distance_decoder_top_tb failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    lsrd_pkg::lsrd_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, range_value", int'(range_value), 0);
      end else begin
        want = expected_results.pop_front();
        if (range_value !== want.range_value)
          report_mismatch("range_value", int'(range_value), int'(want.range_value));
        if (step_index !== want.step_index)
          report_mismatch("step_index", int'(step_index), int'(want.step_index));
        if (scan_end !== want.scan_end)
          report_mismatch("scan_end", int'(scan_end), int'(want.scan_end));
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [lsrd_pkg::BYTE_W-1:0] b);
    lsrd_pkg::lsrd_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, res)) expected_results.push_back(res);
    sent_count++;
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic logic [lsrd_pkg::ADDR_W-1:0] reg_addr(input logic idx);
    return lsrd_pkg::ADDR_W'({idx, 2'b00});
  endfunction

  task automatic apb_access(input logic wr, input logic [lsrd_pkg::ADDR_W-1:0] addr,
                            input logic [lsrd_pkg::DATA_W-1:0] wdata,
                            output logic [lsrd_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_register(input logic idx);
    logic [lsrd_pkg::DATA_W-1:0] rdata;
    apb_access(1'b0, reg_addr(idx), '0, rdata);
    if (idx == lsrd_pkg::REG_FIRST_STEP) begin
      if (rdata[lsrd_pkg::STEP_W-1:0] !== cfg_first_step)
        report_mismatch("first_step readback", int'(rdata[lsrd_pkg::STEP_W-1:0]),
                        int'(cfg_first_step));
    end else begin
      if (rdata[lsrd_pkg::RANGE_W-1:0] !== cfg_max_distance)
        report_mismatch("max_distance readback", int'(rdata[lsrd_pkg::RANGE_W-1:0]),
                        int'(cfg_max_distance));
    end
  endtask

  task automatic configure(input logic [lsrd_pkg::STEP_W-1:0] first_step,
                           input logic [lsrd_pkg::RANGE_W-1:0] max_distance);
    logic [lsrd_pkg::DATA_W-1:0] unused;
    idle_until_drained();
    apb_access(1'b1, reg_addr(lsrd_pkg::REG_FIRST_STEP),
               lsrd_pkg::DATA_W'(first_step), unused);
    cfg_first_step = first_step;
    apb_access(1'b1, reg_addr(lsrd_pkg::REG_MAX_DISTANCE),
               lsrd_pkg::DATA_W'(max_distance), unused);
    cfg_max_distance = max_distance;
    check_register(lsrd_pkg::REG_FIRST_STEP);
    check_register(lsrd_pkg::REG_MAX_DISTANCE);
  endtask

  function automatic logic [lsrd_pkg::BYTE_W-1:0] data_char();
    logic [lsrd_pkg::BYTE_W-1:0] c;
    if ($urandom_range(0, 9) == 0) begin
      c = lsrd_pkg::BYTE_W'($urandom_range(0, 255));
      if (c == lsrd_pkg::CHAR_LF) c = 8'h00;
    end else begin
      c = lsrd_pkg::BYTE_W'($urandom_range(CHAR_ZERO, CHAR_TOP));
    end
    return c;
  endfunction

  task automatic send_header(input bit extra_nine);
    send_byte(lsrd_pkg::CHAR_M);
    send_byte(lsrd_pkg::CHAR_S);
    repeat ($urandom_range(0, 6))
      send_byte(lsrd_pkg::BYTE_W'($urandom_range(CHAR_ZERO, lsrd_pkg::CHAR_NINE)));
    send_byte(lsrd_pkg::CHAR_LF);
    if (extra_nine) send_byte(lsrd_pkg::CHAR_NINE);
    send_byte(lsrd_pkg::CHAR_NINE);
    send_byte(lsrd_pkg::CHAR_NINE);
    send_byte(lsrd_pkg::CHAR_B);
    repeat (STAMP_BYTES) send_byte(lsrd_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // fixed-length scan, lines of line_len pairs each closed by a checksum and LF
  task automatic send_scan(input int n_pairs, input int line_len);
    send_header(1'b0);
    for (int i = 0; i < n_pairs; i++) begin
      send_byte(data_char());
      send_byte(data_char());
      if ((i + 1) % line_len == 0) begin
        send_byte(data_char());
        send_byte(lsrd_pkg::CHAR_LF);
      end
    end
    send_byte(data_char());
    send_byte(lsrd_pkg::CHAR_LF);
    send_byte(lsrd_pkg::CHAR_LF);
  endtask

  task automatic send_reply();
    int n_pairs;
    repeat ($urandom_range(0, 3)) send_byte(lsrd_pkg::BYTE_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      send_byte(lsrd_pkg::CHAR_M);
      send_byte(lsrd_pkg::CHAR_S);
      repeat ($urandom_range(0, 4)) send_byte(lsrd_pkg::BYTE_W'($urandom_range(0, 255)));
      send_byte(lsrd_pkg::CHAR_LF);
      send_byte(lsrd_pkg::CHAR_LF);
      return;
    end
    send_header($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 3)) begin
      n_pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      repeat (n_pairs) begin
        send_byte(data_char());
        send_byte(data_char());
      end
      if ($urandom_range(0, 1)) send_byte(data_char());
      if ($urandom_range(0, 15) == 0) send_byte(lsrd_pkg::BYTE_W'($urandom_range(0, 255)));
      send_byte(lsrd_pkg::CHAR_LF);
    end
    send_byte(lsrd_pkg::CHAR_LF);
  endtask

  task automatic run_replies(input int send_pct, input int recv_pct, input int n_items);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = sent_count;
    while (sent_count - start < n_items) send_reply();
  endtask

  task automatic test_register_readback();
    check_register(lsrd_pkg::REG_FIRST_STEP);
    check_register(lsrd_pkg::REG_MAX_DISTANCE);
    configure(10'd1023, 14'd0);
    configure(lsrd_pkg::FIRST_STEP_RESET, lsrd_pkg::MAX_DISTANCE_RESET);
  endtask

  task automatic test_directed_reply();
    logic [lsrd_pkg::BYTE_W-1:0] seq[] = '{
      lsrd_pkg::CHAR_M, lsrd_pkg::CHAR_M, lsrd_pkg::CHAR_S, lsrd_pkg::CHAR_LF,
      lsrd_pkg::CHAR_NINE, lsrd_pkg::CHAR_NINE, lsrd_pkg::CHAR_NINE, lsrd_pkg::CHAR_B,
      lsrd_pkg::CHAR_LF, 8'h00, 8'hFF, lsrd_pkg::CHAR_LF, lsrd_pkg::CHAR_M,
      lsrd_pkg::CHAR_S, 8'h55,
      CHAR_TOP, CHAR_TOP, CHAR_ZERO, CHAR_ZERO, 8'h20, CHAR_ZERO, 8'h31, lsrd_pkg::CHAR_LF,
      8'h41, 8'h42, lsrd_pkg::CHAR_LF, lsrd_pkg::CHAR_LF,
      lsrd_pkg::CHAR_M, lsrd_pkg::CHAR_S, lsrd_pkg::CHAR_LF, lsrd_pkg::CHAR_LF
    };
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    idle_until_drained();
  endtask

  task automatic test_random_replies();
    configure(lsrd_pkg::STEP_W'($urandom_range(0, 1023)), 14'd16383);
    run_replies(18, 64, 530);
    configure(10'd1023, 14'd0);
    run_replies(64, 18, 530);
    configure(lsrd_pkg::STEP_W'($urandom_range(0, 1023)),
              lsrd_pkg::RANGE_W'($urandom_range(0, 16383)));
    run_replies(0, 0, 530);
  endtask

  task automatic test_backpressure();
    configure(lsrd_pkg::STEP_W'($urandom_range(0, 900)),
              lsrd_pkg::RANGE_W'($urandom_range(0, 16383)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_id++;
    send_scan(40, 16);
    idle_until_drained();
  endtask

  task automatic test_step_saturation();
    configure(10'd990, 14'd16383);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_scan(60, 16);
    idle_until_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_readback();
    test_directed_reply();
    test_random_replies();
    test_backpressure();
    test_step_saturation();
    idle_until_drained();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("laser_scan_reply_distance_decoder_top_tb passed");
    end else begin
      $display("laser_scan_reply_distance_decoder_top_tb failed");
    end
    $finish;
  end

endmodule
